// ===== design/assert_macros.svh =====
// Assertion macros shared by the credential table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// Check that a condition implies another in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

// ===== design/cmt_pkg.sv =====
// Types and constants for the credential match table.
package cmt_pkg;

    localparam int KEY_W    = 32;
    localparam int ID_W     = 8;
    localparam int ACTION_W = 3;
    localparam int VERDICT_W = 2;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_REGISTER = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE   = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_VERIFY   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_TOGGLE   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_QUERY    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR    = 3'd5;

    // Verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_UNKNOWN = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_USER    = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_ADMIN   = 2'd2;

    localparam logic [ID_W-1:0]  ID_FIRST      = 8'd1;
    localparam logic [KEY_W-1:0] ADMIN_KEY_RST = 32'h3030_3030;

    // Request travelling along the row of cells, with its running result
    typedef struct packed {
        logic                vld;
        logic [ACTION_W-1:0] action;
        logic [KEY_W-1:0]    key;
        logic                done;   // slot taken or first match already seen
        logic                found;
        logic [ID_W-1:0]     uid;    // carries the new id on register
        logic                ustat;
    } t_pkt;

endpackage

// ===== design/cmt_cell.sv =====
// One slot of the credential table, acting on the request as it passes.
module cmt_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  cmt_pkg::t_pkt i_pkt,
    output cmt_pkg::t_pkt o_pkt
);

    logic                       r_valid;
    logic                       n_valid;
    logic [cmt_pkg::KEY_W-1:0]  r_key;
    logic [cmt_pkg::KEY_W-1:0]  n_key;
    logic [cmt_pkg::ID_W-1:0]   r_id;
    logic [cmt_pkg::ID_W-1:0]   n_id;
    logic                       r_status;
    logic                       n_status;
    cmt_pkg::t_pkt              r_pkt;
    cmt_pkg::t_pkt              n_pkt;
    logic                       w_match;

    assign w_match = r_valid && (r_key == i_pkt.key);

    // Apply the request to this slot and update the running result
    always_comb begin
        n_pkt    = i_pkt;
        n_valid  = r_valid;
        n_key    = r_key;
        n_id     = r_id;
        n_status = r_status;
        if (i_pkt.vld) begin
            case (i_pkt.action)
                cmt_pkg::ACT_REGISTER: begin
                    if (!i_pkt.done && !r_valid) begin
                        n_valid     = 1'b1;
                        n_key       = i_pkt.key;
                        n_id        = i_pkt.uid;
                        n_status    = 1'b0;
                        n_pkt.done  = 1'b1;
                        n_pkt.found = 1'b1;
                    end
                end
                cmt_pkg::ACT_REMOVE: begin
                    if (w_match) begin
                        n_valid = 1'b0;
                        if (!i_pkt.done) begin
                            n_pkt.done  = 1'b1;
                            n_pkt.found = 1'b1;
                            n_pkt.uid   = r_id;
                        end
                    end
                end
                cmt_pkg::ACT_VERIFY, cmt_pkg::ACT_QUERY: begin
                    if (w_match && !i_pkt.done) begin
                        n_pkt.done  = 1'b1;
                        n_pkt.found = 1'b1;
                        n_pkt.uid   = r_id;
                        n_pkt.ustat = r_status;
                    end
                end
                cmt_pkg::ACT_TOGGLE: begin
                    if (w_match && !i_pkt.done) begin
                        n_status    = ~r_status;
                        n_pkt.done  = 1'b1;
                        n_pkt.found = 1'b1;
                        n_pkt.uid   = r_id;
                        n_pkt.ustat = ~r_status;
                    end
                end
                cmt_pkg::ACT_CLEAR: begin
                    n_valid = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Hold the slot valid bit and the outgoing request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pkt   <= '0;
        end else if (i_adv) begin
            r_valid <= n_valid;
            r_pkt   <= n_pkt;
        end
    end

    // Hold the slot contents
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_key    <= n_key;
            r_id     <= n_id;
            r_status <= n_status;
        end
    end

    assign o_pkt = r_pkt;

endmodule

// ===== design/credential_match_table.sv =====
// Credential match table: a row of user slots scanned by a travelling request.
//
// Usage:
//   Slave stream (i_s_*): one request per transfer, tdata = {key, action}.
//   Master stream (o_m_*): one result per request, tdata = {table_full,
//   user_id, user_status, verdict, found}.
//   Config channel (i_cfg_*): writes the administrator key; ready only while
//   no request is in flight, and a pending write holds off new requests.
// Timing:
//   A request steps through TABLE_ROWS-1 slot cells, one cell per cycle
//   unless the row is stalled, and lands in the output register. One
//   request is in the row at a time, so a new one is taken only once the
//   previous result is registered.
// Reset:
//   All slots become free, the next id returns to 1 and the administrator
//   key returns to ASCII "0000". No scan of the slot store is needed.
// Stall:
//   A held result does not block input; a request reaching the end of the
//   row waits in the last cell until the output register frees.
`include "assert_macros.svh"

module credential_match_table #(
    parameter int TABLE_ROWS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [2:0] action, [34:3] key, [39:35] zero
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [0] found, [2:1] verdict, [3] user_status,
                                     // [11:4] user_id, [12] table_full, [15:13] zero
    // Administrator key write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data   // admin_key
);

    localparam int USER_SLOTS = TABLE_ROWS - 1;

    cmt_pkg::t_pkt                  w_pkt [0:USER_SLOTS];
    cmt_pkg::t_pkt                  w_end;
    logic                           w_adv;
    logic                           w_s_xfer;
    logic                           w_exit;
    logic [USER_SLOTS-1:0]          w_stage_vld;

    logic                           r_busy;
    logic                           r_out_vld;
    logic [15:0]                    r_out_data;
    logic [15:0]                    n_out_data;
    logic [cmt_pkg::ID_W-1:0]       r_next_id;
    logic [cmt_pkg::KEY_W-1:0]      r_admin_key;

    logic                           w_found;
    logic [cmt_pkg::VERDICT_W-1:0]  w_verdict;
    logic                           w_ustat;
    logic [cmt_pkg::ID_W-1:0]       w_uid;
    logic                           w_full;

    // Hold off requests while a key write waits; take key writes only when idle
    assign o_s_tready  = !r_busy && !i_cfg_valid;
    assign w_s_xfer    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = !r_busy;
    assign w_end       = w_pkt[USER_SLOTS];
    assign w_adv       = !(w_end.vld && r_out_vld && !i_m_tready);
    assign w_exit      = w_end.vld && w_adv;

    // Build the request entering the first cell
    always_comb begin
        w_pkt[0].vld    = w_s_xfer;
        w_pkt[0].action = i_s_tdata[2:0];
        w_pkt[0].key    = i_s_tdata[34:3];
        w_pkt[0].done   = 1'b0;
        w_pkt[0].found  = 1'b0;
        w_pkt[0].uid    = (i_s_tdata[2:0] == cmt_pkg::ACT_REGISTER) ? r_next_id : '0;
        w_pkt[0].ustat  = 1'b0;
    end

    // Row of slot cells
    for (genvar g = 0; g < USER_SLOTS; g++) begin : g_cell
        cmt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_pkt   (w_pkt[g]),
            .o_pkt   (w_pkt[g+1])
        );
        assign w_stage_vld[g] = w_pkt[g+1].vld;
    end

    // Finish the result at the end of the row
    always_comb begin
        w_found   = w_end.found;
        w_verdict = cmt_pkg::VERDICT_UNKNOWN;
        w_ustat   = w_end.ustat;
        w_uid     = w_end.uid;
        w_full    = 1'b0;
        case (w_end.action)
            cmt_pkg::ACT_REGISTER: begin
                if (!w_end.done) begin
                    w_full  = 1'b1;
                    w_found = 1'b0;
                    w_uid   = '0;
                end
            end
            cmt_pkg::ACT_VERIFY: begin
                if (w_end.key == r_admin_key) begin
                    w_found   = 1'b1;
                    w_verdict = cmt_pkg::VERDICT_ADMIN;
                end else if (w_end.found) begin
                    w_verdict = cmt_pkg::VERDICT_USER;
                end
            end
            default: begin
            end
        endcase
        n_out_data = {3'b000, w_full, w_uid, w_ustat, w_verdict, w_found};
    end

    // Control: busy flag, output valid, id counter, admin key
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_vld   <= 1'b0;
            r_next_id   <= cmt_pkg::ID_FIRST;
            r_admin_key <= cmt_pkg::ADMIN_KEY_RST;
        end else begin
            if (w_s_xfer) begin
                r_busy <= 1'b1;
            end else if (w_exit) begin
                r_busy <= 1'b0;
            end
            if (w_exit) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
            if (w_exit && w_end.action == cmt_pkg::ACT_REGISTER && w_end.done) begin
                r_next_id <= r_next_id + 1'b1;
            end else if (w_exit && w_end.action == cmt_pkg::ACT_CLEAR) begin
                r_next_id <= cmt_pkg::ID_FIRST;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_admin_key <= i_cfg_data;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_exit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    // Only one request travels the row at a time
    `ASSERT_IMPL(a_one_in_row, i_clk, i_rst_n, 1'b1, $countones(w_stage_vld) <= 1)
    // A request in the row always has the input side closed
    `ASSERT_IMPL(a_busy_in_row, i_clk, i_rst_n, w_stage_vld != '0, r_busy)
    // An accepted request closes the input side next cycle
    `ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, w_s_xfer, r_busy)
    // A full table reports no id and no match
    `ASSERT_IMPL(a_full_clean, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[12],
        o_m_tdata[11:0] == 12'd0)

endmodule

// ===== bench/credential_match_table_tb.sv =====
// Self-checking bench for the credential match table: directed and random requests.
module credential_match_table_tb;

    localparam int TABLE_ROWS     = 16;
    localparam int SLOTS          = TABLE_ROWS - 1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 66;
    localparam int POOL_SIZE      = 6;

    // Action codes the block ignores
    localparam logic [cmt_pkg::ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [cmt_pkg::ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    typedef struct packed {
        logic [cmt_pkg::KEY_W-1:0]    key;
        logic [cmt_pkg::ACTION_W-1:0] action;
    } t_request;

    typedef struct packed {
        logic                          full;
        logic [cmt_pkg::ID_W-1:0]      uid;
        logic                          ustat;
        logic [cmt_pkg::VERDICT_W-1:0] verdict;
        logic                          found;
    } t_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata   = '0;   // [2:0] action, [34:3] key, [39:35] zero
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [15:0] o_m_tdata;          // [0] found, [2:1] verdict, [3] user_status,
                                     // [11:4] user_id, [12] table_full, [15:13] zero
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data  = '0;   // admin_key

    // Shadow copy of the slot store and the administrator key
    logic                      slot_used [SLOTS] = '{default: 1'b0};
    logic [cmt_pkg::KEY_W-1:0] slot_key  [SLOTS];
    logic [cmt_pkg::ID_W-1:0]  slot_uid  [SLOTS];
    logic                      slot_flag [SLOTS];
    logic [cmt_pkg::ID_W-1:0]  id_next          = cmt_pkg::ID_FIRST;
    logic [cmt_pkg::KEY_W-1:0] admin_key_shadow = cmt_pkg::ADMIN_KEY_RST;

    t_request                  pending_requests[$];
    t_result                   expected_results[$];
    logic [cmt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
    int                        send_idle_pct = 0;
    int                        recv_idle_pct = 0;
    int                        mismatch_count = 0;
    int                        stall_cycles = 0;

    credential_match_table #(
        .TABLE_ROWS (TABLE_ROWS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Apply one request to the shadow table and return the result it should give
    function automatic t_result lookup_and_update(t_request rq);
        t_result r;
        int      hit;
        int      free_slot;
        r = '0;
        hit = -1;
        free_slot = -1;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_key[i] == rq.key) hit = i;
            if (!slot_used[i]) free_slot = i;
        end
        case (rq.action)
            cmt_pkg::ACT_REGISTER: begin
                if (free_slot < 0) begin
                    r.full = 1'b1;
                end else begin
                    slot_used[free_slot] = 1'b1;
                    slot_key[free_slot]  = rq.key;
                    slot_uid[free_slot]  = id_next;
                    slot_flag[free_slot] = 1'b0;
                    r.found = 1'b1;
                    r.uid   = id_next;
                    id_next = id_next + 8'd1;
                end
            end
            cmt_pkg::ACT_REMOVE: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.uid   = slot_uid[hit];
                    for (int i = 0; i < SLOTS; i++)
                        if (slot_used[i] && slot_key[i] == rq.key) slot_used[i] = 1'b0;
                end
            end
            cmt_pkg::ACT_VERIFY: begin
                if (hit >= 0) begin
                    r.found   = 1'b1;
                    r.uid     = slot_uid[hit];
                    r.ustat   = slot_flag[hit];
                    r.verdict = cmt_pkg::VERDICT_USER;
                end
                // administrator key wins over a user match
                if (rq.key == admin_key_shadow) begin
                    r.found   = 1'b1;
                    r.verdict = cmt_pkg::VERDICT_ADMIN;
                end
            end
            cmt_pkg::ACT_TOGGLE: begin
                if (hit >= 0) begin
                    slot_flag[hit] = ~slot_flag[hit];
                    r.found = 1'b1;
                    r.uid   = slot_uid[hit];
                    r.ustat = slot_flag[hit];
                end
            end
            cmt_pkg::ACT_QUERY: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.uid   = slot_uid[hit];
                    r.ustat = slot_flag[hit];
                end
            end
            cmt_pkg::ACT_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
                id_next = cmt_pkg::ID_FIRST;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic add_request(logic [cmt_pkg::ACTION_W-1:0] act,
                               logic [cmt_pkg::KEY_W-1:0] k);
        t_request rq;
        rq.action = act;
        rq.key    = k;
        pending_requests.push_back(rq);
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Wait for every request to be answered, then let the pipeline drain
    task automatic settle();
        while (pending_requests.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (TABLE_ROWS + 4) @(posedge i_clk);
    endtask

    task automatic write_admin_key(logic [cmt_pkg::KEY_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        admin_key_shadow = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Random requests over a small key pool so that lookups hit often
    task automatic add_random_phase(int count);
        int                           made;
        int                           pick;
        logic [cmt_pkg::KEY_W-1:0]    k;
        logic [cmt_pkg::ACTION_W-1:0] act;
        made = 0;
        key_pool[0] = admin_key_shadow;
        key_pool[1] = '0;
        key_pool[2] = '1;
        key_pool[3] = $urandom;
        key_pool[4] = $urandom;
        key_pool[5] = admin_key_shadow ^ (32'd1 << $urandom_range(31));
        while (made < count) begin
            if ($urandom_range(99) < 85) k = key_pool[$urandom_range(POOL_SIZE - 1)];
            else k = $urandom;
            pick = $urandom_range(99);
            if (pick < 34)      act = cmt_pkg::ACT_REGISTER;
            else if (pick < 50) act = cmt_pkg::ACT_REMOVE;
            else if (pick < 66) act = cmt_pkg::ACT_VERIFY;
            else if (pick < 78) act = cmt_pkg::ACT_TOGGLE;
            else if (pick < 90) act = cmt_pkg::ACT_QUERY;
            else if (pick < 93) act = cmt_pkg::ACT_CLEAR;
            else if (pick < 96) act = ACT_SPARE_A;
            else                act = ACT_SPARE_B;
            add_request(act, k);
            // ignored actions do not count towards the phase
            if (act != ACT_SPARE_A && act != ACT_SPARE_B) made++;
        end
    endtask

    // Driver: present queued requests, hold each until its transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                expected_results.push_back(lookup_and_update(pending_requests.pop_front()));
            if (!i_s_tvalid || o_s_tready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= {5'b0, pending_requests[0]};
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random, compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_m_tvalid && i_m_tready) begin
                got = o_m_tdata[12:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, o_m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("verdict", want.verdict, got.verdict);
                    check_field("user_status", want.ustat, got.ustat);
                    check_field("user_id", want.uid, got.uid);
                    check_field("table_full", want.full, got.full);
                end
            end
        end
    end

    // Watchdog: end the run when no transfer of any kind happens for too long
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("credential_match_table_tb failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [cmt_pkg::KEY_W-1:0] admin_values [6];
        admin_values[0] = '0;
        admin_values[1] = '1;
        admin_values[2] = $urandom;
        admin_values[3] = cmt_pkg::ADMIN_KEY_RST;
        admin_values[4] = $urandom;
        admin_values[5] = $urandom;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, ignored action, fill to full, admin over user, clear
        send_idle_pct = 22;
        recv_idle_pct = 58;
        add_request(cmt_pkg::ACT_VERIFY, cmt_pkg::ADMIN_KEY_RST);
        add_request(cmt_pkg::ACT_REMOVE, 32'hFFFF_FFFF);
        add_request(ACT_SPARE_B, 32'hFFFF_FFFF);
        add_request(cmt_pkg::ACT_REGISTER, 32'h0000_0000);
        add_request(cmt_pkg::ACT_REGISTER, 32'hFFFF_FFFF);
        add_request(cmt_pkg::ACT_REGISTER, cmt_pkg::ADMIN_KEY_RST);
        add_request(cmt_pkg::ACT_REGISTER, 32'hFFFF_FFFF);
        for (int i = 4; i < SLOTS; i++) add_request(cmt_pkg::ACT_REGISTER, $urandom);
        add_request(cmt_pkg::ACT_REGISTER, 32'h1234_5678);
        add_request(cmt_pkg::ACT_VERIFY, cmt_pkg::ADMIN_KEY_RST);
        add_request(cmt_pkg::ACT_TOGGLE, 32'hFFFF_FFFF);
        add_request(cmt_pkg::ACT_VERIFY, 32'hFFFF_FFFF);
        add_request(cmt_pkg::ACT_REMOVE, 32'hFFFF_FFFF);
        add_request(cmt_pkg::ACT_REGISTER, 32'h8000_0001);
        add_request(cmt_pkg::ACT_CLEAR, 32'h0000_0000);
        add_request(cmt_pkg::ACT_QUERY, 32'h0000_0000);
        settle();

        // Random phases: receiver-heavy idling, then sender-heavy, then none
        for (int p = 0; p < 6; p++) begin
            if (p < 2) begin
                send_idle_pct = 22;
                recv_idle_pct = 58;
            end else if (p < 4) begin
                send_idle_pct = 58;
                recv_idle_pct = 22;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_admin_key(admin_values[p]);
            add_random_phase(PHASE_ITEMS);
            settle();
        end

        if (expected_results.size() != 0) begin
            $display("%0t: %0d results missing, expected more, actual none",
                     $time, expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("credential_match_table_tb passed");
        end else begin
            $display("credential_match_table_tb failed");
        end
        $finish;
    end

endmodule
